// File: rtl/assert_macros.svh
// Assertion macros shared by the CSV tokenizer RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define CSVT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define CSVT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/csvt_pkg.sv
// Package for the CSV tokenizer: payload structs, result codes, lexer modes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package csvt_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [2:0] KIND_BYTE     = 3'd0;
  localparam logic [2:0] KIND_CELL_END = 3'd1;
  localparam logic [2:0] KIND_ROW_END  = 3'd2;
  localparam logic [2:0] KIND_ERROR    = 3'd3;
  localparam logic [2:0] KIND_DONE     = 3'd4;

  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_AFTER_QUOTE  = 2'd1;
  localparam logic [1:0] ERR_STRAY_QUOTE  = 2'd2;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd3;

  // Most results one input byte can produce.
  localparam int unsigned RUN_MAX = 3;

  typedef enum logic [1:0] {
    MODE_UNQUOTED   = 2'd0,
    MODE_QUOTED     = 2'd1,
    MODE_QUOTE_SEEN = 2'd2,
    MODE_ERROR      = 2'd3
  } lexer_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] cell_byte;
    logic [1:0] error_kind;
    logic       last_of_run;
  } out_item_t;

  // All results of one input byte; the final one carries last_of_run.
  typedef struct packed {
    out_item_t [RUN_MAX-1:0] items;
  } run_t;

  function automatic out_item_t make_item(logic [2:0] kind, logic [7:0] b, logic [1:0] err);
    out_item_t it;
    it.result_kind = kind;
    it.cell_byte   = b;
    it.error_kind  = err;
    it.last_of_run = 1'b0;
    return it;
  endfunction

endpackage

// File: rtl/csvt_run_fifo.sv
// Two-entry queue of result runs between the lexer front and the output back.
// Depends on csvt_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csvt_run_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  csvt_pkg::run_t push_run,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output csvt_pkg::run_t head_run
);

  csvt_pkg::run_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_run   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

  `CSVT_ASSERT(a_no_push_full, !(push && full), "run pushed into full queue")
  `CSVT_ASSERT(a_no_pop_empty, !(pop && !head_valid), "run popped from empty queue")
  `CSVT_ASSERT(a_count_range, count_r != 2'd3, "queue count out of range")

endmodule

// File: rtl/csvt_front.sv
// Lexer front: accepts CSV bytes, tracks quoting and row state, and builds the
// run of results each byte causes. Depends on csvt_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csvt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  csvt_pkg::in_item_t in_item,
  output logic               push,
  output csvt_pkg::run_t     push_run
);

  csvt_pkg::lexer_mode_t mode_r, mode_nxt;
  logic empty_r, empty_nxt;
  logic row_r, row_nxt;
  logic cr_r, cr_nxt;

  logic [7:0] b;
  logic       fin;
  logic       is_quote, is_comma, is_cr, is_lf;
  logic       skip_lf;

  // per-byte decisions
  logic                  do_content, do_cell_end, do_line, set_cr;
  logic [1:0]            err;
  csvt_pkg::lexer_mode_t mode_mid;
  logic                  empty_mid, row_mid;
  logic                  line_emit, fin_row;

  logic [1:0]     cnt;
  csvt_pkg::run_t run;

  assign b        = in_item.data_byte;
  assign fin      = in_item.end_of_input;
  assign is_quote = (b == csvt_pkg::CH_QUOTE);
  assign is_comma = (b == csvt_pkg::CH_COMMA);
  assign is_cr    = (b == csvt_pkg::CH_CR);
  assign is_lf    = (b == csvt_pkg::CH_LF);
  // LF right after an unquoted CR is part of the same line end
  assign skip_lf  = cr_r && is_lf && (mode_r == csvt_pkg::MODE_UNQUOTED);

  // Byte decode
  always_comb begin
    do_content  = 1'b0;
    do_cell_end = 1'b0;
    do_line     = 1'b0;
    set_cr      = 1'b0;
    err         = csvt_pkg::ERR_NONE;
    mode_mid    = mode_r;
    if (!skip_lf) begin
      unique case (mode_r)
        csvt_pkg::MODE_QUOTED: begin
          if (is_quote) mode_mid = csvt_pkg::MODE_QUOTE_SEEN;
          else          do_content = 1'b1;
        end
        csvt_pkg::MODE_QUOTE_SEEN: begin
          if (is_quote) begin
            do_content = 1'b1;
            mode_mid   = csvt_pkg::MODE_QUOTED;
          end else if (is_comma) begin
            do_cell_end = 1'b1;
            mode_mid    = csvt_pkg::MODE_UNQUOTED;
          end else if (is_cr || is_lf) begin
            do_line  = 1'b1;
            set_cr   = is_cr;
            mode_mid = csvt_pkg::MODE_UNQUOTED;
          end else begin
            err = csvt_pkg::ERR_AFTER_QUOTE;
          end
        end
        csvt_pkg::MODE_UNQUOTED: begin
          if (is_quote) begin
            if (empty_r) mode_mid = csvt_pkg::MODE_QUOTED;
            else         err = csvt_pkg::ERR_STRAY_QUOTE;
          end else if (is_comma) begin
            do_cell_end = 1'b1;
          end else if (is_cr || is_lf) begin
            do_line = 1'b1;
            set_cr  = is_cr;
          end else begin
            do_content = 1'b1;
          end
        end
        csvt_pkg::MODE_ERROR: begin
        end
        default: begin
        end
      endcase
    end
    line_emit = do_line && (row_r || !empty_r);
    if (do_content)                    empty_mid = 1'b0;
    else if (do_cell_end || do_line)   empty_mid = 1'b1;
    else                               empty_mid = empty_r;
    if (do_cell_end)  row_mid = 1'b1;
    else if (do_line) row_mid = 1'b0;
    else              row_mid = row_r;
    fin_row = row_mid || !empty_mid;
  end

  // Next state
  always_comb begin
    mode_nxt  = mode_r;
    empty_nxt = empty_r;
    row_nxt   = row_r;
    cr_nxt    = cr_r;
    if (accept) begin
      if (fin) begin
        mode_nxt  = csvt_pkg::MODE_UNQUOTED;
        empty_nxt = 1'b1;
        row_nxt   = 1'b0;
        cr_nxt    = 1'b0;
      end else if (mode_r == csvt_pkg::MODE_ERROR) begin
        mode_nxt = csvt_pkg::MODE_ERROR;
      end else if (err != csvt_pkg::ERR_NONE) begin
        mode_nxt = csvt_pkg::MODE_ERROR;
        cr_nxt   = 1'b0;
      end else begin
        mode_nxt  = mode_mid;
        empty_nxt = empty_mid;
        row_nxt   = row_mid;
        cr_nxt    = set_cr;
      end
    end
  end

  // Outputs: results in the order the byte produces them
  always_comb begin
    run = '0;
    cnt = 2'd0;
    if (mode_r != csvt_pkg::MODE_ERROR) begin
      if (do_content) begin
        run.items[cnt] = csvt_pkg::make_item(csvt_pkg::KIND_BYTE, b, csvt_pkg::ERR_NONE);
        cnt = cnt + 2'd1;
      end
      if (do_cell_end) begin
        run.items[cnt] = csvt_pkg::make_item(csvt_pkg::KIND_CELL_END, 8'd0,
                                             csvt_pkg::ERR_NONE);
        cnt = cnt + 2'd1;
      end
      if (line_emit) begin
        run.items[cnt] = csvt_pkg::make_item(csvt_pkg::KIND_ROW_END, 8'd0,
                                             csvt_pkg::ERR_NONE);
        cnt = cnt + 2'd1;
      end
      if (err != csvt_pkg::ERR_NONE) begin
        run.items[cnt] = csvt_pkg::make_item(csvt_pkg::KIND_ERROR, 8'd0, err);
        cnt = cnt + 2'd1;
      end else if (fin) begin
        if (mode_mid == csvt_pkg::MODE_QUOTED) begin
          run.items[cnt] = csvt_pkg::make_item(csvt_pkg::KIND_ERROR, 8'd0,
                                               csvt_pkg::ERR_UNTERMINATED);
          cnt = cnt + 2'd1;
        end else begin
          if (fin_row) begin
            run.items[cnt] = csvt_pkg::make_item(csvt_pkg::KIND_ROW_END, 8'd0,
                                                 csvt_pkg::ERR_NONE);
            cnt = cnt + 2'd1;
          end
          run.items[cnt] = csvt_pkg::make_item(csvt_pkg::KIND_DONE, 8'd0,
                                               csvt_pkg::ERR_NONE);
          cnt = cnt + 2'd1;
        end
      end
    end
    case (cnt)
      2'd1:    run.items[0].last_of_run = 1'b1;
      2'd2:    run.items[1].last_of_run = 1'b1;
      2'd3:    run.items[2].last_of_run = 1'b1;
      default: ;
    endcase
  end

  assign push     = accept && (cnt != 2'd0);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= csvt_pkg::MODE_UNQUOTED;
      empty_r <= 1'b1;
      row_r   <= 1'b0;
      cr_r    <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      empty_r <= empty_nxt;
      row_r   <= row_nxt;
      cr_r    <= cr_nxt;
    end
  end

  `CSVT_ASSERT(a_fin_resets, accept && fin |=> mode_r == csvt_pkg::MODE_UNQUOTED && empty_r && !row_r && !cr_r, "final byte did not reset lexer")
  `CSVT_ASSERT(a_error_silent, accept && mode_r == csvt_pkg::MODE_ERROR |-> !push, "result produced while in error mode")

endmodule

// File: rtl/csvt_back.sv
// Output back: takes result runs from the queue and hands them out one result
// per cycle while out_ready is high, from a registered run. Depends on csvt_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csvt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  csvt_pkg::run_t      head_run,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output csvt_pkg::out_item_t out_data
);

  logic           busy_r, busy_nxt;
  logic [1:0]     idx_r, idx_nxt;
  csvt_pkg::run_t run_r;
  csvt_pkg::out_item_t cur;
  logic           taken, run_done;

  always_comb begin
    case (idx_r)
      2'd0:    cur = run_r.items[0];
      2'd1:    cur = run_r.items[1];
      default: cur = run_r.items[2];
    endcase
  end

  assign taken    = busy_r && out_ready;
  assign run_done = taken && cur.last_of_run;
  assign pop      = head_valid && (!busy_r || run_done);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (run_done) begin
      busy_nxt = 1'b0;
      idx_nxt  = 2'd0;
    end else if (taken) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      run_r <= head_run;
    end
  end

  assign out_valid = busy_r;
  assign out_data  = cur;

  `CSVT_ASSERT(a_idx_range, busy_r |-> idx_r != 2'd3, "result index past run end")
  `CSVT_ASSERT(a_run_continues, taken && !cur.last_of_run |=> busy_r && idx_r == $past(idx_r) + 2'd1, "run cut short")

endmodule

// File: rtl/csv_cell_tokenizer.sv
// Top level of the streaming CSV cell tokenizer.
// Depends on csvt_pkg, csvt_front, csvt_run_fifo, csvt_back.
`timescale 1ns / 1ps

// Streaming CSV tokenizer. Each request on the in_ channel is one document
// byte plus an end-of-input flag; the out_ channel returns cell bytes,
// cell-end and row-end markers, and a done or syntax-error result, with
// last_of_run set on the final result caused by each byte. Bytes that cause
// no result (a quote opening a cell, the LF of CR LF, anything after an
// error) leave nothing on the output. Rate: one byte per cycle is accepted
// while the queue is not full; the lexer front decides each byte in the cycle
// it is taken. The output back delivers one result per cycle while out_ready
// is high; a byte's run holds up to three results, and the final byte is the
// only one that can yield more than one. A two-run queue decouples the two
// sides, so a stalled output stops input only once both queue entries and the
// output run register are occupied. A run goes from the queue to that register.
module csv_cell_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csvt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csvt_pkg::out_item_t out_data
);

  logic           accept;
  logic           push, full, pop, head_valid;
  csvt_pkg::run_t push_run, head_run;

  // The front takes a byte whenever the queue has room for its run.
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  csvt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_data),
    .push     (push),
    .push_run (push_run)
  );

  csvt_run_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_run   (push_run),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_run   (head_run)
  );

  csvt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_run   (head_run),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
